>>> src/imm_pkg.sv
// Shared constants and types for the integer matrix multiply core.
`timescale 1ns / 1ps
`default_nettype none

package imm_pkg;

    // Largest matrix dimension held in the element stores.
    localparam int MAX_DIM     = 16;
    localparam int IDX_W       = 4;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Widths of the data path and of the size registers.
    localparam int DATA_W = 32;
    localparam int CFG_W  = 5;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Item opcodes carried on the action field.
    typedef enum logic [1:0] {
        ACT_WRITE_A = 2'd0,
        ACT_WRITE_B = 2'd1,
        ACT_COMPUTE = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    // Size register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_ROWS_A = 2'd0,
        REG_COLS_A = 2'd1,
        REG_COLS_B = 2'd2,
        REG_UNUSED = 2'd3
    } reg_index_t;

    // Sequencer states of the dot product engine.
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_RUN   = 2'd1,
        ST_DRAIN = 2'd2
    } state_t;

    // Clamp a size register to the store dimension.
    function automatic logic [CFG_W-1:0] sat_dim(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] lim;
        lim = CFG_W'(MAX_DIM);
        return (v > lim) ? lim : v;
    endfunction

endpackage

`default_nettype wire

>>> src/integer_matrix_multiply_core.sv
// Top level of the integer matrix multiply core: stores, sequencer and MAC.
//
//  Channel   Handshake              Payload
//  -------   --------------------   ----------------------------------------
//  item      start & !busy          action, row, col, value
//  result    result_valid (strobe)  product_value, index_error
//  config    psel & penable &       paddr, pwdata (rows_a, cols_a, cols_b)
//            pwrite & pready
//
// A write item leaves busy low. A compute with an index error or an
// empty dot product gives its result in the next cycle.
// Otherwise one A and one B element are read per cycle and the MAC adds one
// term per cycle: busy stays high until the last product has been added, and
// the result strobe comes in the same cycle as busy falls.
// Reset sets all sizes to 16 and leaves the stores; results cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module integer_matrix_multiply_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        action,
    input  wire logic [imm_pkg::IDX_W-1:0]         row,
    input  wire logic [imm_pkg::IDX_W-1:0]         col,
    input  wire logic signed [imm_pkg::DATA_W-1:0] value,
    output logic                                   result_valid,
    output logic signed [imm_pkg::DATA_W-1:0]      product_value,
    output logic                                   index_error,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [imm_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [imm_pkg::PDATA_W-1:0]       pwdata,
    output logic [imm_pkg::PDATA_W-1:0]            prdata,
    output logic                                   pready
);

    localparam int AW = imm_pkg::ADDR_W;
    localparam int DW = imm_pkg::DATA_W;
    localparam int CW = imm_pkg::CFG_W;
    localparam int IW = imm_pkg::IDX_W;

    // Size registers.
    logic [CW-1:0] rows_a_reg;
    logic [CW-1:0] cols_a_reg;
    logic [CW-1:0] cols_b_reg;

    // Sequencer and data path registers.
    imm_pkg::state_t state_reg, state_next;
    logic [IW-1:0]   k_reg;
    logic [IW-1:0]   row_reg;
    logic [IW-1:0]   col_reg;
    logic [CW-1:0]   n_reg;
    logic            rd_vld_reg;
    logic            mul_vld_reg;
    logic [DW-1:0]   prod_reg;
    logic [DW-1:0]   acc_reg;
    logic            result_valid_reg;
    logic [DW-1:0]   product_value_reg;
    logic            index_error_reg;

    // Decoded item and control.
    logic            accept;
    imm_pkg::action_t act;
    logic            cfg_write;
    imm_pkg::reg_index_t cfg_idx;
    logic            range_err;
    logic [CW-1:0]   n_eff;
    logic            compute_now;
    logic            quick_result;
    logic            issue;
    logic            last_issue;
    logic            finish;
    logic            pipe_empty;

    // Store ports.
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_a_addr;
    logic [AW-1:0]   rd_b_addr;
    logic [DW-1:0]   rd_a_data;
    logic [DW-1:0]   rd_b_data;
    logic [DW-1:0]   mul_low;

    // Item transfer and decode.
    assign accept    = start && !busy;
    assign act       = imm_pkg::action_t'(action);
    assign range_err = (CW'(row) >= imm_pkg::sat_dim(rows_a_reg))
                    || (CW'(col) >= imm_pkg::sat_dim(cols_b_reg));
    assign n_eff     = imm_pkg::sat_dim(cols_a_reg);
    assign compute_now  = accept && (act == imm_pkg::ACT_COMPUTE);
    assign quick_result = compute_now && (range_err || (n_eff == '0));
    assign wr_addr   = AW'(row) * AW'(imm_pkg::MAX_DIM) + AW'(col);

    // Configuration port: always ready, reads return the size registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = imm_pkg::reg_index_t'(paddr[3:2]);

    always_comb
    begin
        case (cfg_idx)
            imm_pkg::REG_ROWS_A: prdata = imm_pkg::PDATA_W'(rows_a_reg);
            imm_pkg::REG_COLS_A: prdata = imm_pkg::PDATA_W'(cols_a_reg);
            imm_pkg::REG_COLS_B: prdata = imm_pkg::PDATA_W'(cols_b_reg);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg <= CW'(16);
            cols_a_reg <= CW'(16);
            cols_b_reg <= CW'(16);
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                imm_pkg::REG_ROWS_A: rows_a_reg <= pwdata[CW-1:0];
                imm_pkg::REG_COLS_A: cols_a_reg <= pwdata[CW-1:0];
                imm_pkg::REG_COLS_B: cols_b_reg <= pwdata[CW-1:0];
                default:             ;
            endcase
        end
    end

    // Element stores.
    imm_ram #(.WIDTH(DW), .DEPTH(imm_pkg::STORE_DEPTH)) u_a_store (
        .clk     (clk),
        .wr_en   (accept && (act == imm_pkg::ACT_WRITE_A)),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_en   (issue),
        .rd_addr (rd_a_addr),
        .rd_data (rd_a_data)
    );

    imm_ram #(.WIDTH(DW), .DEPTH(imm_pkg::STORE_DEPTH)) u_b_store (
        .clk     (clk),
        .wr_en   (accept && (act == imm_pkg::ACT_WRITE_B)),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_en   (issue),
        .rd_addr (rd_b_addr),
        .rd_data (rd_b_data)
    );

    // Read addresses walk along row of A and down column of B.
    assign rd_a_addr  = AW'(row_reg) * AW'(imm_pkg::MAX_DIM) + AW'(k_reg);
    assign rd_b_addr  = AW'(k_reg) * AW'(imm_pkg::MAX_DIM) + AW'(col_reg);
    assign last_issue = (CW'(k_reg) == (n_reg - CW'(1)));
    assign pipe_empty = !rd_vld_reg && !mul_vld_reg;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            imm_pkg::ST_IDLE:
            begin
                if (compute_now && !quick_result)
                begin
                    state_next = imm_pkg::ST_RUN;
                end
            end
            imm_pkg::ST_RUN:
            begin
                if (last_issue)
                begin
                    state_next = imm_pkg::ST_DRAIN;
                end
            end
            imm_pkg::ST_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = imm_pkg::ST_IDLE;
                end
            end
            default: state_next = imm_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        busy   = 1'b1;
        issue  = 1'b0;
        finish = 1'b0;
        case (state_reg)
            imm_pkg::ST_IDLE:  busy = 1'b0;
            imm_pkg::ST_RUN:   issue = 1'b1;
            imm_pkg::ST_DRAIN: finish = pipe_empty;
            default:           busy = 1'b0;
        endcase
    end

    // Low half of the element product, registered before the adder.
    assign mul_low = DW'(rd_a_data * rd_b_data);

    // Control registers of the sequencer and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= imm_pkg::ST_IDLE;
            k_reg            <= '0;
            rd_vld_reg       <= 1'b0;
            mul_vld_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rd_vld_reg       <= issue;
            mul_vld_reg      <= rd_vld_reg;
            result_valid_reg <= quick_result || finish;
            if (compute_now)
            begin
                k_reg <= '0;
            end
            else if (issue)
            begin
                k_reg <= k_reg + IW'(1);
            end
        end
    end

    // Payload registers: item indexes, product, accumulator and result.
    always_ff @(posedge clk)
    begin
        if (compute_now)
        begin
            row_reg <= row;
            col_reg <= col;
            n_reg   <= n_eff;
            acc_reg <= '0;
        end
        else if (mul_vld_reg)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
        if (rd_vld_reg)
        begin
            prod_reg <= mul_low;
        end
        if (quick_result)
        begin
            product_value_reg <= '0;
            index_error_reg   <= range_err;
        end
        else if (finish)
        begin
            product_value_reg <= acc_reg;
            index_error_reg   <= 1'b0;
        end
    end

    assign result_valid  = result_valid_reg;
    assign product_value = product_value_reg;
    assign index_error   = index_error_reg;

endmodule

`default_nettype wire

>>> src/imm_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> src/imm_checker.sv
// Port-level checker for the integer matrix multiply core, bound to the top.
`timescale 1ns / 1ps
`default_nettype none

module imm_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic [1:0]                        action,
    input wire logic                              result_valid,
    input wire logic signed [imm_pkg::DATA_W-1:0] product_value,
    input wire logic                              index_error
);

    // A compute transfer either answers at once or keeps the core busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == imm_pkg::ACT_COMPUTE))
        |=> (result_valid || busy))
    else $error("compute transfer neither answered nor started");

    // Write and unused transfers never produce a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action != imm_pkg::ACT_COMPUTE)) |=> !result_valid)
    else $error("result without a compute transfer");

    // A result closes the compute, so the core is free in that cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
    else $error("busy while a result is shown");

    // An index error result carries a zero product.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && index_error) |-> (product_value == '0))
    else $error("index error with nonzero product");

    // Busy only rises after a compute transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && (action == imm_pkg::ACT_COMPUTE)))
    else $error("busy rose without a compute transfer");

endmodule

bind integer_matrix_multiply_core imm_checker u_imm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .result_valid  (result_valid),
    .product_value (product_value),
    .index_error   (index_error)
);

`default_nettype wire
